### hw/rtl/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // configuration registers
    localparam int THRESH_W   = 34;
    localparam int TOL_W      = 16;      // tolerance is Q0.TOL_W
    localparam int TOL_RESET  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(1);

    // result flags in tuser
    localparam int USER_W     = 2;
    localparam int USER_HIT   = 0;
    localparam int USER_PAR   = 1;

endpackage

### hw/rtl/segment_segment_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_intersection
// Fixed-point 2D segment/segment intersection test, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while the output side is not stalled, and
// returns one result per pair, in order. The pipeline has PARAM_FRAC_BITS + 10
// register stages; the depth is set by the restoring divider that forms the
// parameter t one quotient bit per stage. Every stage has its own valid bit and
// moves whenever the stage after it is free, so a stall on the output side only
// fills bubbles first.
// Registers are written through the cfg port and must only change while the
// pipeline is empty.
module segment_segment_intersection
    import ssi_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cfg write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata from bit 0: a_start_x, a_start_y, a_end_x, a_end_y,
    //                   b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata from bit 0: cross_x, cross_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser from bit 0: hit, parallel
    output logic [USER_W-1:0]     o_m_axis_tuser
);

    localparam int CW   = COORD_BITS;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int OW   = ((2*CW+7)/8)*8;
    localparam int DW   = CW + 1;               // coordinate differences
    localparam int PW   = 2 * DW;               // difference products
    localparam int XW   = PW + 1;               // det and numerators
    localparam int CMPW = (XW > THRESH_W) ? XW : THRESH_W;
    localparam int RW   = XW + TOL_W + 2;       // range test
    localparam int QW   = F + 2;                // raw quotient
    localparam int TW   = F + 1;                // rounded t
    localparam int MW   = DW + TW + 1;          // offset product

    // stage numbers
    localparam int S_DIFF = 0;
    localparam int S_PROD = 1;
    localparam int S_DET  = 2;
    localparam int S_NORM = 3;
    localparam int S_TOLM = 4;
    localparam int S_RNG  = 5;
    localparam int S_DIV0 = 6;
    localparam int S_TQ   = S_DIV0 + F + 1;
    localparam int S_MUL  = S_TQ + 1;
    localparam int S_OUT  = S_MUL + 1;
    localparam int NS     = S_OUT + 1;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [DW-1:0] dax;
        logic signed [DW-1:0] day;
        logic                 par;
        logic                 ok;
    } t_side;

    // ---------------- configuration ----------------
    logic [THRESH_W-1:0] r_thr;
    logic [TOL_W-1:0]    r_tol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_tol <= TOL_W'(TOL_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THRESH_W-1:0];
                CFG_TOLERANCE: r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---------------- sideband ----------------
    t_side r_side [NS-1];
    t_side n_side [NS-1];

    logic signed [CW-1:0] w_ax, w_ay, w_aex, w_aey, w_bx, w_by, w_bex, w_bey;
    assign w_ax  = i_s_axis_tdata[0*CW +: CW];
    assign w_ay  = i_s_axis_tdata[1*CW +: CW];
    assign w_aex = i_s_axis_tdata[2*CW +: CW];
    assign w_aey = i_s_axis_tdata[3*CW +: CW];
    assign w_bx  = i_s_axis_tdata[4*CW +: CW];
    assign w_by  = i_s_axis_tdata[5*CW +: CW];
    assign w_bex = i_s_axis_tdata[6*CW +: CW];
    assign w_bey = i_s_axis_tdata[7*CW +: CW];

    logic w_par;
    logic w_ok;

    always_comb begin
        for (int k = 1; k < NS - 1; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[S_DIFF].ax  = w_ax;
        n_side[S_DIFF].ay  = w_ay;
        n_side[S_DIFF].dax = DW'(w_aex) - DW'(w_ax);
        n_side[S_DIFF].day = DW'(w_aey) - DW'(w_ay);
        n_side[S_DIFF].par = 1'b0;
        n_side[S_DIFF].ok  = 1'b0;
        n_side[S_NORM].par = w_par;
        n_side[S_RNG].ok   = w_ok;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS - 1; k++) begin
            if (en[k]) r_side[k] <= n_side[k];
        end
    end

    // ---------------- S_DIFF: B direction and offset ----------------
    logic signed [DW-1:0] r_dbx, r_dby, r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (en[S_DIFF]) begin
            r_dbx <= DW'(w_bex) - DW'(w_bx);
            r_dby <= DW'(w_bey) - DW'(w_by);
            r_ox  <= DW'(w_bx) - DW'(w_ax);
            r_oy  <= DW'(w_by) - DW'(w_ay);
        end
    end

    // ---------------- S_PROD: six cross terms ----------------
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    always_ff @(posedge i_clk) begin
        if (en[S_PROD]) begin
            r_p0 <= r_dbx * r_side[S_DIFF].day;
            r_p1 <= r_dby * r_side[S_DIFF].dax;
            r_p2 <= r_dbx * r_oy;
            r_p3 <= r_dby * r_ox;
            r_p4 <= r_side[S_DIFF].dax * r_oy;
            r_p5 <= r_side[S_DIFF].day * r_ox;
        end
    end

    // ---------------- S_DET: det, t and s numerators ----------------
    logic signed [XW-1:0] r_det, r_tn, r_sn;

    always_ff @(posedge i_clk) begin
        if (en[S_DET]) begin
            r_det <= XW'(r_p0) - XW'(r_p1);
            r_tn  <= XW'(r_p2) - XW'(r_p3);
            r_sn  <= XW'(r_p4) - XW'(r_p5);
        end
    end

    // ---------------- S_NORM: make det positive, parallel test ----------------
    logic [XW-1:0]        w_mag;
    logic [XW-1:0]        r_d3;
    logic signed [XW-1:0] r_tn3, r_sn3;

    assign w_mag = r_det[XW-1] ? XW'(-r_det) : XW'(r_det);
    assign w_par = CMPW'(w_mag) <= CMPW'(r_thr);

    always_ff @(posedge i_clk) begin
        if (en[S_NORM]) begin
            r_d3  <= w_mag;
            r_tn3 <= r_det[XW-1] ? -r_tn : r_tn;
            r_sn3 <= r_det[XW-1] ? -r_sn : r_sn;
        end
    end

    // ---------------- S_TOLM: tol * det ----------------
    logic [TOL_W+XW-1:0]  r_told;
    logic [XW-1:0]        r_d4;
    logic signed [XW-1:0] r_tn4, r_sn4;

    always_ff @(posedge i_clk) begin
        if (en[S_TOLM]) begin
            r_told <= r_tol * r_d3;
            r_d4   <= r_d3;
            r_tn4  <= r_tn3;
            r_sn4  <= r_sn3;
        end
    end

    // ---------------- S_RNG: range test, clamp t, first quotient bit ----------------
    // n/d in [-tol, 1+tol]  <=>  -tol*d <= n*2^16 <= d*2^16 + tol*d
    logic signed [RW-1:0] w_lo, w_hi, w_tsh, w_ssh;
    logic [XW-1:0]        w_tc;
    logic                 w_q0;

    assign w_lo  = -$signed(RW'(r_told));
    assign w_hi  = $signed(RW'(r_d4) << TOL_W) + $signed(RW'(r_told));
    assign w_tsh = RW'(r_tn4) <<< TOL_W;
    assign w_ssh = RW'(r_sn4) <<< TOL_W;
    assign w_ok  = (w_tsh >= w_lo) && (w_tsh <= w_hi) &&
                   (w_ssh >= w_lo) && (w_ssh <= w_hi);

    always_comb begin
        if (r_tn4 < 0) begin
            w_tc = '0;
        end else if (r_tn4 > $signed(r_d4)) begin
            w_tc = r_d4;
        end else begin
            w_tc = XW'(r_tn4);
        end
    end
    assign w_q0 = (w_tc == r_d4);

    logic [XW-1:0] r_r5, r_d5;
    logic          r_q5;

    always_ff @(posedge i_clk) begin
        if (en[S_RNG]) begin
            r_r5 <= w_q0 ? '0 : w_tc;
            r_d5 <= r_d4;
            r_q5 <= w_q0;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic [XW-1:0] r_dr [F+1];
    logic [XW-1:0] r_dd [F+1];
    logic [QW-1:0] r_dq [F+1];

    for (genvar g = 0; g <= F; g++) begin : g_div
        logic [XW-1:0] w_rin, w_din;
        logic [QW-1:0] w_qin;
        logic [XW:0]   w_r2;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_rin = r_r5;
            assign w_din = r_d5;
            assign w_qin = QW'(r_q5);
        end else begin : g_next
            assign w_rin = r_dr[g-1];
            assign w_din = r_dd[g-1];
            assign w_qin = r_dq[g-1];
        end

        assign w_r2 = {w_rin, 1'b0};
        assign w_ge = w_r2 >= {1'b0, w_din};

        always_ff @(posedge i_clk) begin
            if (en[S_DIV0+g]) begin
                r_dr[g] <= w_ge ? XW'(w_r2 - {1'b0, w_din}) : XW'(w_r2);
                r_dd[g] <= w_din;
                r_dq[g] <= {w_qin[QW-2:0], w_ge};
            end
        end
    end

    // ---------------- S_TQ: round t to nearest, ties up ----------------
    logic [QW-1:0] w_qp1;
    logic [TW-1:0] r_tq;

    assign w_qp1 = r_dq[F] + QW'(1);

    always_ff @(posedge i_clk) begin
        if (en[S_TQ]) r_tq <= w_qp1[QW-1:1];
    end

    // ---------------- S_MUL: direction times t ----------------
    logic signed [MW-1:0] r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (en[S_MUL]) begin
            r_mx <= r_side[S_TQ].dax * $signed({1'b0, r_tq});
            r_my <= r_side[S_TQ].day * $signed({1'b0, r_tq});
        end
    end

    // ---------------- S_OUT: round away from zero, add start ----------------
    logic [MW-1:0]        w_magx, w_magy, w_offx, w_offy;
    logic signed [MW-1:0] w_sx, w_sy;
    logic                 w_hit;
    t_side                w_so;

    assign w_so   = r_side[S_MUL];
    assign w_magx = r_mx[MW-1] ? MW'(-r_mx) : MW'(r_mx);
    assign w_magy = r_my[MW-1] ? MW'(-r_my) : MW'(r_my);
    assign w_offx = (w_magx + (MW'(1) << (F - 1))) >> F;
    assign w_offy = (w_magy + (MW'(1) << (F - 1))) >> F;
    assign w_sx   = MW'(w_so.ax) + (r_mx[MW-1] ? -$signed(w_offx) : $signed(w_offx));
    assign w_sy   = MW'(w_so.ay) + (r_my[MW-1] ? -$signed(w_offy) : $signed(w_offy));
    assign w_hit  = !w_so.par && w_so.ok;

    logic          r_hit, r_par;
    logic [CW-1:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_hit <= w_hit;
            r_par <= w_so.par;
            r_cx  <= w_hit ? w_sx[CW-1:0] : '0;
            r_cy  <= w_hit ? w_sy[CW-1:0] : '0;
        end
    end

    assign o_m_axis_tvalid          = r_v[S_OUT];
    assign o_m_axis_tdata           = OW'({r_cy, r_cx});
    assign o_m_axis_tuser[USER_HIT] = r_hit;
    assign o_m_axis_tuser[USER_PAR] = r_par;

endmodule

### hw/rtl/ssi_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_chk
// Port-level checks for the segment intersection block.
// ----------------------------------------------------------------------------
module ssi_chk
    import ssi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [((2*COORD_BITS+7)/8)*8-1:0]  o_m_axis_tdata,
    input logic [USER_W-1:0]                  o_m_axis_tuser
);

    // pipeline is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    // parallel pairs never hit
    a_par_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[USER_PAR] |-> !o_m_axis_tuser[USER_HIT])
        else $error("hit flagged on a parallel pair");

    // no hit means a zero point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[USER_HIT] |-> o_m_axis_tdata == '0)
        else $error("point not zero on a miss");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind segment_segment_intersection ssi_chk #(.COORD_BITS(COORD_BITS)) u_ssi_chk (.*);
